// ===== src/cfpe_pkg.sv =====
// Shared types and constants of the cluster-formation packet engine.
package cfpe_pkg;

  localparam int HEAD_FIELDS = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 3;

  // Request types carried by req_type.
  localparam logic REQ_PKT   = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Packet kinds, on input and on output.
  localparam logic [1:0] KIND_HEAD = 2'd0;
  localparam logic [1:0] KIND_TOPO = 2'd1;
  localparam logic [1:0] KIND_JOIN = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ID   = 3'd0,
    CFG_IS_SINK   = 3'd1,
    CFG_HOP_LIMIT = 3'd2,
    CFG_HEAD_ID0  = 3'd3,
    CFG_HEAD_ID1  = 3'd4,
    CFG_HEAD_ID2  = 3'd5,
    CFG_HEAD_ID3  = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [6:0] RST_NODE_ID   = 7'd0;
  localparam logic       RST_IS_SINK   = 1'b0;
  localparam logic [7:0] RST_HOP_LIMIT = 8'd8;
  localparam logic [6:0] RST_HEAD_ID0  = 7'd22;
  localparam logic [6:0] RST_HEAD_ID1  = 7'd27;
  localparam logic [6:0] RST_HEAD_ID2  = 7'd72;
  localparam logic [6:0] RST_HEAD_ID3  = 7'd77;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  pkt_kind;
    logic [31:0] seq_num;
    logic [7:0]  hops;
    logic [2:0]  head_count;
    logic [6:0]  head0;
    logic [6:0]  head1;
    logic [6:0]  head2;
    logic [6:0]  head3;
    logic [6:0]  source_id;
    logic [6:0]  dest_id;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic [1:0]  out_kind;
    logic [31:0] out_seq;
    logic [7:0]  out_hops;
    logic [2:0]  out_head_count;
    logic [6:0]  out_head0;
    logic [6:0]  out_head1;
    logic [6:0]  out_head2;
    logic [6:0]  out_head3;
    logic [6:0]  out_source_id;
    logic [6:0]  out_dest_id;
  } out_item_t;

  // Work handed from the front part to the back part: one or two results.
  typedef struct packed {
    out_item_t pkt0;
    out_item_t pkt1;
    logic      two;
  } job_t;

endpackage

// ===== src/cfpe_front.sv =====
// Front part: configuration registers, node state and per-item classification.
module cfpe_front #(
  parameter int NODE_COUNT = 128,
  parameter int MAX_HEADS  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cfpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfpe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  cfpe_pkg::in_item_t             in_item,
  output logic                           push,
  output cfpe_pkg::job_t                 push_job
);
  import cfpe_pkg::*;

  localparam int HEAD_CAP = (MAX_HEADS < HEAD_FIELDS) ? MAX_HEADS : HEAD_FIELDS;
  localparam int MAP_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [2:0] CAP3 = 3'(HEAD_CAP);

  logic [6:0] node_id_r;
  logic       is_sink_r;
  logic [7:0] hop_limit_r;
  logic [6:0] head_id_r [HEAD_FIELDS];

  logic [31:0] head_seq_r, head_seq_nxt;
  logic [31:0] topo_seq_r, topo_seq_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        head_known_r, head_known_nxt;
  logic [6:0]  my_head_r, my_head_nxt;
  logic [6:0]  relay_node_r, relay_node_nxt;
  logic [NODE_COUNT-1:0] member_map_r;

  logic             accept;
  logic             clear;
  logic             map_we;
  logic [MAP_W-1:0] map_idx;
  logic [31:0]      src_ext;
  logic [2:0]       cnt;
  logic [6:0]       hd [HEAD_FIELDS];
  logic             listed;
  logic             was_head;
  logic [1:0]       n_res;
  out_item_t        p0, p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= RST_NODE_ID;
      is_sink_r    <= RST_IS_SINK;
      hop_limit_r  <= RST_HOP_LIMIT;
      head_id_r[0] <= RST_HEAD_ID0;
      head_id_r[1] <= RST_HEAD_ID1;
      head_id_r[2] <= RST_HEAD_ID2;
      head_id_r[3] <= RST_HEAD_ID3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:   node_id_r    <= cfg_data[6:0];
        CFG_IS_SINK:   is_sink_r    <= cfg_data[0];
        CFG_HOP_LIMIT: hop_limit_r  <= cfg_data[7:0];
        CFG_HEAD_ID0:  head_id_r[0] <= cfg_data[6:0];
        CFG_HEAD_ID1:  head_id_r[1] <= cfg_data[6:0];
        CFG_HEAD_ID2:  head_id_r[2] <= cfg_data[6:0];
        CFG_HEAD_ID3:  head_id_r[3] <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_seq_r   <= '0;
      topo_seq_r   <= '0;
      level_r      <= '0;
      head_known_r <= 1'b0;
      my_head_r    <= '0;
      relay_node_r <= '0;
    end else begin
      head_seq_r   <= head_seq_nxt;
      topo_seq_r   <= topo_seq_nxt;
      level_r      <= level_nxt;
      head_known_r <= head_known_nxt;
      my_head_r    <= my_head_nxt;
      relay_node_r <= relay_node_nxt;
    end
  end

  // The member map is only ever set one bit at a time and cleared as a whole.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      member_map_r <= '0;
    end else if (map_we) begin
      member_map_r[map_idx] <= 1'b1;
    end
  end

  assign accept  = in_valid && !in_stall;
  assign src_ext = 32'(in_item.source_id);
  assign map_idx = src_ext[MAP_W-1:0];
  assign cnt     = (in_item.head_count > CAP3) ? CAP3 : in_item.head_count;
  assign hd[0]   = in_item.head0;
  assign hd[1]   = in_item.head1;
  assign hd[2]   = in_item.head2;
  assign hd[3]   = in_item.head3;

  always_comb begin
    listed = 1'b0;
    for (int i = 0; i < HEAD_FIELDS; i++) begin
      if (3'(i) < cnt && hd[i] == node_id_r) begin
        listed = 1'b1;
      end
    end
  end

  assign was_head = head_known_r && (my_head_r == node_id_r);

  always_comb begin
    head_seq_nxt   = head_seq_r;
    topo_seq_nxt   = topo_seq_r;
    level_nxt      = level_r;
    head_known_nxt = head_known_r;
    my_head_nxt    = my_head_r;
    relay_node_nxt = relay_node_r;
    clear          = 1'b0;
    map_we         = 1'b0;
    n_res          = 2'd0;
    p0             = '0;
    p1             = '0;

    if (accept) begin
      if (in_item.req_type == REQ_START) begin
        clear          = 1'b1;
        head_seq_nxt   = '0;
        topo_seq_nxt   = '0;
        level_nxt      = '0;
        head_known_nxt = 1'b0;
        my_head_nxt    = '0;
        relay_node_nxt = '0;
        if (is_sink_r) begin
          head_seq_nxt     = 32'd1;
          n_res            = 2'd1;
          p0.out_kind      = KIND_HEAD;
          p0.out_seq       = 32'd1;
          p0.out_hops      = hop_limit_r;
          p0.out_head_count = CAP3;
          p0.out_head0     = (3'd0 < CAP3) ? head_id_r[0] : 7'd0;
          p0.out_head1     = (3'd1 < CAP3) ? head_id_r[1] : 7'd0;
          p0.out_head2     = (3'd2 < CAP3) ? head_id_r[2] : 7'd0;
          p0.out_head3     = (3'd3 < CAP3) ? head_id_r[3] : 7'd0;
          p0.out_source_id = node_id_r;
        end
      end else if (!is_sink_r && in_item.hops != 8'd0) begin
        case (in_item.pkt_kind)
          KIND_HEAD: begin
            if (in_item.seq_num > head_seq_r) begin
              head_seq_nxt      = in_item.seq_num;
              n_res             = 2'd1;
              p0.out_kind       = KIND_HEAD;
              p0.out_seq        = in_item.seq_num;
              p0.out_hops       = in_item.hops - 8'd1;
              p0.out_head_count = cnt;
              p0.out_head0      = (3'd0 < cnt) ? hd[0] : 7'd0;
              p0.out_head1      = (3'd1 < cnt) ? hd[1] : 7'd0;
              p0.out_head2      = (3'd2 < cnt) ? hd[2] : 7'd0;
              p0.out_head3      = (3'd3 < cnt) ? hd[3] : 7'd0;
              p0.out_source_id  = in_item.source_id;
              if (listed) begin
                head_known_nxt = 1'b1;
                my_head_nxt    = node_id_r;
                level_nxt      = hop_limit_r;
                // A node that is already head re-announces itself only for a new flood round.
                if (!was_head || topo_seq_r != in_item.seq_num) begin
                  topo_seq_nxt      = in_item.seq_num;
                  n_res             = 2'd2;
                  p1.out_kind       = KIND_TOPO;
                  p1.out_seq        = in_item.seq_num;
                  p1.out_hops       = hop_limit_r;
                  p1.out_head_count = 3'd1;
                  p1.out_head0      = node_id_r;
                  p1.out_source_id  = node_id_r;
                end
              end
            end
          end
          KIND_TOPO: begin
            if (in_item.seq_num >= topo_seq_r) begin
              topo_seq_nxt = in_item.seq_num;
              if (!head_known_r || level_r <= in_item.hops) begin
                level_nxt         = in_item.hops;
                my_head_nxt       = hd[0];
                head_known_nxt    = 1'b1;
                relay_node_nxt    = in_item.source_id;
                n_res             = 2'd2;
                p0.out_kind       = KIND_TOPO;
                p0.out_seq        = in_item.seq_num;
                p0.out_hops       = in_item.hops - 8'd1;
                p0.out_head_count = cnt;
                p0.out_head0      = (3'd0 < cnt) ? hd[0] : 7'd0;
                p0.out_head1      = (3'd1 < cnt) ? hd[1] : 7'd0;
                p0.out_head2      = (3'd2 < cnt) ? hd[2] : 7'd0;
                p0.out_head3      = (3'd3 < cnt) ? hd[3] : 7'd0;
                p0.out_source_id  = node_id_r;
                p1.out_kind       = KIND_JOIN;
                p1.out_hops       = hop_limit_r;
                p1.out_source_id  = node_id_r;
                p1.out_dest_id    = in_item.source_id;
              end
            end
          end
          KIND_JOIN: begin
            if (in_item.dest_id == node_id_r) begin
              if (was_head) begin
                map_we = (src_ext < 32'(NODE_COUNT));
              end else begin
                n_res            = 2'd1;
                p0.out_kind      = KIND_JOIN;
                p0.out_hops      = in_item.hops;
                p0.out_source_id = in_item.source_id;
                p0.out_dest_id   = relay_node_r;
              end
            end
          end
          default: ;
        endcase
      end
    end

    p0.last = (n_res == 2'd1);
    p1.last = 1'b1;
  end

  assign push          = accept && (n_res != 2'd0);
  assign push_job.pkt0 = p0;
  assign push_job.pkt1 = p1;
  assign push_job.two  = (n_res == 2'd2);

endmodule

// ===== src/cfpe_queue.sv =====
// Two-entry job queue between the front part and the back part.
module cfpe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfpe_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output cfpe_pkg::job_t q_job
);
  import cfpe_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_job   = mem_r[rd_ptr_r];

endmodule

// ===== src/cfpe_back.sv =====
// Back part: sends the one or two results of each job through an output register.
module cfpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cfpe_pkg::job_t      q_job,
  output logic                q_pop,
  input  logic                out_stall,
  output logic                out_valid,
  output cfpe_pkg::out_item_t out_item
);
  import cfpe_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      sel_r, sel_nxt;
  logic      load;
  logic      last_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= sel_r ? q_job.pkt1 : q_job.pkt0;
    end
  end

  // The register takes a new item when it is empty or its item leaves now.
  assign load     = q_valid && (!out_valid_r || !out_stall);
  assign last_sel = sel_r || !q_job.two;
  assign q_pop    = load && last_sel;

  always_comb begin
    sel_nxt = sel_r;
    if (load) begin
      sel_nxt = !last_sel;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/cluster_formation_packet_engine.sv =====
// Top level of the cluster-formation packet engine.
// Each accepted item is classified and applied to the node state in the cycle it is
// taken; the one or two result items it causes go into a two-entry job queue, and an
// output register sends them out one item per cycle while out_stall is low, the results
// of one item in order. Input stall rises only when the job queue is full, so new items
// can be taken while the results of earlier items are still being sent.
// Reset and a start item clear the member map as a whole, with no clearing pass.
module cluster_formation_packet_engine #(
  parameter int NODE_COUNT = 128,
  parameter int MAX_HEADS  = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfpe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cfpe_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cfpe_pkg::out_item_t             out_item
);
  import cfpe_pkg::*;

  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic q_valid;
  job_t q_job;

  assign in_stall = full;

  cfpe_front #(
    .NODE_COUNT(NODE_COUNT),
    .MAX_HEADS (MAX_HEADS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (full),
    .in_item  (in_item),
    .push     (push),
    .push_job (push_job)
  );

  cfpe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (full),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  cfpe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// ===== tb/cluster_formation_packet_engine_tb.sv =====
// Self-checking testbench of the cluster-formation packet engine: directed table, then random traffic.
module cluster_formation_packet_engine_tb;
  import cfpe_pkg::*;

  localparam int         HEAD_CAP     = 4;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef logic [0:3][6:0] head_list_t;

  typedef struct {
    int        ph;
    in_item_t  it;
    bit        typed;
    int        n;
    out_item_t e0;
    out_item_t e1;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;

  // Configuration as the block holds it.
  logic [6:0] cur_node;
  logic       cur_sink;
  logic [7:0] cur_hop;
  head_list_t cur_heads;

  // Node state as predicted.
  logic [31:0]  st_head_seq;
  logic [31:0]  st_topo_seq;
  logic [7:0]   st_level;
  logic         st_head_known;
  logic [6:0]   st_my_head;
  logic [6:0]   st_relay;
  logic [127:0] st_members;

  out_item_t pred_res [0:1];
  out_item_t outgoing_q [$];
  row_t      plan [$];
  int        mismatch_count = 0;
  bit        tx_calm = 0;
  bit        rx_calm = 0;

  cluster_formation_packet_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_item_t pkt(logic req, logic [1:0] kind, logic [31:0] seq,
                                   logic [7:0] hops, logic [2:0] cnt, head_list_t h,
                                   logic [6:0] src, logic [6:0] dst);
    in_item_t it;
    it.req_type   = req;
    it.pkt_kind   = kind;
    it.seq_num    = seq;
    it.hops       = hops;
    it.head_count = cnt;
    it.head0      = h[0];
    it.head1      = h[1];
    it.head2      = h[2];
    it.head3      = h[3];
    it.source_id  = src;
    it.dest_id    = dst;
    return it;
  endfunction

  // Heads past the count go out as zero.
  function automatic out_item_t make_out(logic [1:0] kind, logic [31:0] seq, logic [7:0] hops,
                                         int cnt, head_list_t h, logic [6:0] src,
                                         logic [6:0] dst);
    out_item_t o;
    o                = '0;
    o.out_kind       = kind;
    o.out_seq        = seq;
    o.out_hops       = hops;
    o.out_head_count = 3'(cnt);
    o.out_head0      = (cnt > 0) ? h[0] : 7'd0;
    o.out_head1      = (cnt > 1) ? h[1] : 7'd0;
    o.out_head2      = (cnt > 2) ? h[2] : 7'd0;
    o.out_head3      = (cnt > 3) ? h[3] : 7'd0;
    o.out_source_id  = src;
    o.out_dest_id    = dst;
    return o;
  endfunction

  function automatic void clear_node_state();
    st_head_seq   = '0;
    st_topo_seq   = '0;
    st_level      = '0;
    st_head_known = 1'b0;
    st_my_head    = '0;
    st_relay      = '0;
    st_members    = '0;
  endfunction

  // Applies one item to the predicted node state and leaves its packets in pred_res.
  function automatic int node_step(in_item_t it);
    int         n;
    int         cnt;
    bit         listed;
    bit         was_head;
    head_list_t hs;
    n   = 0;
    cnt = (it.head_count > HEAD_CAP) ? HEAD_CAP : int'(it.head_count);
    hs  = {it.head0, it.head1, it.head2, it.head3};
    if (it.req_type == REQ_START) begin
      clear_node_state();
      if (cur_sink) begin
        st_head_seq = st_head_seq + 32'd1;
        pred_res[n] = make_out(KIND_HEAD, st_head_seq, cur_hop, HEAD_CAP, cur_heads, cur_node,
                               7'd0);
        n++;
      end
    end else if (!cur_sink && it.hops != 8'd0) begin
      case (it.pkt_kind)
        KIND_HEAD: begin
          if (it.seq_num > st_head_seq) begin
            st_head_seq = it.seq_num;
            pred_res[n] = make_out(KIND_HEAD, it.seq_num, it.hops - 8'd1, cnt, hs,
                                   it.source_id, 7'd0);
            n++;
            listed = 1'b0;
            for (int i = 0; i < cnt; i++)
              if (hs[i] == cur_node) listed = 1'b1;
            if (listed) begin
              was_head      = st_head_known && st_my_head == cur_node;
              st_head_known = 1'b1;
              st_my_head    = cur_node;
              st_level      = cur_hop;
              // A head that already announced this round stays quiet.
              if (!was_head || st_topo_seq != st_head_seq) begin
                st_topo_seq = st_head_seq;
                pred_res[n] = make_out(KIND_TOPO, st_topo_seq, cur_hop, 1, {cur_node, 21'd0},
                                       cur_node, 7'd0);
                n++;
              end
            end
          end
        end
        KIND_TOPO: begin
          if (it.seq_num >= st_topo_seq) begin
            st_topo_seq = it.seq_num;
            if (!st_head_known || st_level <= it.hops) begin
              st_level      = it.hops;
              st_my_head    = hs[0];
              st_head_known = 1'b1;
              st_relay      = it.source_id;
              pred_res[n] = make_out(KIND_TOPO, it.seq_num, it.hops - 8'd1, cnt, hs, cur_node,
                                     7'd0);
              n++;
              pred_res[n] = make_out(KIND_JOIN, 32'd0, cur_hop, 0, '0, cur_node, st_relay);
              n++;
            end
          end
        end
        KIND_JOIN: begin
          if (it.dest_id == cur_node) begin
            if (st_head_known && st_my_head == cur_node)
              st_members[it.source_id] = 1'b1;
            else begin
              pred_res[n] = make_out(KIND_JOIN, 32'd0, it.hops, 0, '0, it.source_id, st_relay);
              n++;
            end
          end
        end
        default: ;
      endcase
    end
    if (n > 0) pred_res[n-1].last = 1'b1;
    return n;
  endfunction

  // Mostly well-formed traffic built around the current state, with some noise.
  function automatic in_item_t random_packet();
    logic [95:0] raw;
    in_item_t    it;
    int          r;
    int          lvl;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[87:0];
    r   = $urandom_range(0, 99);
    if (r < (cur_sink ? 25 : 3)) begin
      it.req_type = REQ_START;
      return it;
    end
    it.req_type = REQ_PKT;
    r = $urandom_range(0, 99);
    if (r < 32)      it.pkt_kind = KIND_HEAD;
    else if (r < 64) it.pkt_kind = KIND_TOPO;
    else if (r < 95) it.pkt_kind = KIND_JOIN;
    else             it.pkt_kind = KIND_UNKNOWN;
    it.hops = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    if ($urandom_range(0, 3) != 0) it.head_count = 3'($urandom_range(0, 4));
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: it.head0 = cur_node;
        1: it.head1 = cur_node;
        2: it.head2 = cur_node;
        default: it.head3 = cur_node;
      endcase
    end
    r = $urandom_range(0, 99);
    case (it.pkt_kind)
      KIND_HEAD: begin
        if (r < 75)      it.seq_num = st_head_seq + 32'($urandom_range(1, 3));
        else if (r < 85) it.seq_num = st_head_seq - 32'($urandom_range(0, 2));
      end
      KIND_TOPO: begin
        if (r < 70)      it.seq_num = st_topo_seq + 32'($urandom_range(0, 2));
        else if (r < 85) it.seq_num = st_topo_seq - 32'd1;
        if ($urandom_range(0, 1) == 1) begin
          lvl = int'(st_level) + int'($urandom_range(0, 3)) - 1;
          if (lvl < 1)   lvl = 1;
          if (lvl > 255) lvl = 255;
          it.hops = 8'(lvl);
        end
      end
      KIND_JOIN: begin
        if ($urandom_range(0, 4) != 0) it.dest_id = cur_node;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic add_pred(int ph, in_item_t it);
    row_t row;
    row.ph    = ph;
    row.it    = it;
    row.typed = 1'b0;
    row.n     = 0;
    row.e0    = '0;
    row.e1    = '0;
    plan.push_back(row);
  endtask

  task automatic add_typed(int ph, in_item_t it, int n, out_item_t e0, out_item_t e1);
    row_t row;
    row.ph      = ph;
    row.it      = it;
    row.typed   = 1'b1;
    row.n       = n;
    row.e0      = e0;
    row.e1      = e1;
    row.e0.last = (n == 1);
    row.e1.last = 1'b1;
    plan.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_packet(in_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Waits until every predicted packet has come out, then lets the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (outgoing_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_config(logic [6:0] node, logic sink, logic [7:0] hop, head_list_t h);
    cfg_reg_t   regs [7];
    logic [7:0] vals [7];
    regs = '{CFG_NODE_ID, CFG_IS_SINK, CFG_HOP_LIMIT, CFG_HEAD_ID0, CFG_HEAD_ID1,
             CFG_HEAD_ID2, CFG_HEAD_ID3};
    vals = '{{1'b0, node}, {7'd0, sink}, hop, {1'b0, h[0]}, {1'b0, h[1]}, {1'b0, h[2]},
             {1'b0, h[3]}};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    cur_node  = node;
    cur_sink  = sink;
    cur_hop   = hop;
    cur_heads = h;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : rx_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outgoing_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: no packet expected, actual %h", $time, out_item);
      end else begin
        want = outgoing_q.pop_front();
        check_field("last", 32'(want.last), 32'(out_item.last));
        check_field("out_kind", 32'(want.out_kind), 32'(out_item.out_kind));
        check_field("out_seq", want.out_seq, out_item.out_seq);
        check_field("out_hops", 32'(want.out_hops), 32'(out_item.out_hops));
        check_field("out_head_count", 32'(want.out_head_count),
                    32'(out_item.out_head_count));
        check_field("out_head0", 32'(want.out_head0), 32'(out_item.out_head0));
        check_field("out_head1", 32'(want.out_head1), 32'(out_item.out_head1));
        check_field("out_head2", 32'(want.out_head2), 32'(out_item.out_head2));
        check_field("out_head3", 32'(want.out_head3), 32'(out_item.out_head3));
        check_field("out_source_id", 32'(want.out_source_id), 32'(out_item.out_source_id));
        check_field("out_dest_id", 32'(want.out_dest_id), 32'(out_item.out_dest_id));
      end
    end
  end

  // Receiver: holds stall for a drawn number of cycles before each packet.
  initial begin
    int w;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      w = rx_calm ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    head_list_t ph_heads [4];
    logic [6:0] ph_node [4];
    logic       ph_sink [4];
    logic [7:0] ph_hop [4];
    head_list_t rst_list;
    head_list_t hl;
    in_item_t   it;
    int         n;
    int         cur_ph;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_NODE_ID;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    rst_list  = {RST_HEAD_ID0, RST_HEAD_ID1, RST_HEAD_ID2, RST_HEAD_ID3};
    cur_node  = RST_NODE_ID;
    cur_sink  = RST_IS_SINK;
    cur_hop   = RST_HOP_LIMIT;
    cur_heads = rst_list;
    clear_node_state();

    // Directed phases: reset values, sink at the extremes, hop limit zero, a plain node.
    ph_node  = '{RST_NODE_ID, 7'd127, 7'd127, 7'd3};
    ph_sink  = '{RST_IS_SINK, 1'b1, 1'b0, 1'b0};
    ph_hop   = '{RST_HOP_LIMIT, 8'd255, 8'd0, 8'd100};
    ph_heads = '{rst_list, {7'd127, 7'd0, 7'd127, 7'd0}, {7'd0, 7'd127, 7'd0, 7'd127},
                 {7'd1, 7'd2, 7'd3, 7'd4}};

    add_typed(0, pkt(REQ_START, KIND_HEAD, 0, 0, 0, '0, 0, 0), 0, '0, '0);
    add_typed(0, pkt(REQ_PKT, KIND_HEAD, 1, 255, 4, rst_list, 5, 0), 1,
              make_out(KIND_HEAD, 1, 254, 4, rst_list, 5, 0), '0);
    add_typed(0, pkt(REQ_PKT, KIND_HEAD, 1, 200, 4, rst_list, 5, 0), 0, '0, '0);
    add_typed(0, pkt(REQ_PKT, KIND_HEAD, 5, 0, 4, rst_list, 5, 0), 0, '0, '0);
    add_typed(0, pkt(REQ_PKT, KIND_UNKNOWN, 9, 1, 4, rst_list, 5, 0), 0, '0, '0);
    // Oversized count saturates, and this node is named as a head.
    add_pred(0, pkt(REQ_PKT, KIND_HEAD, 2, 9, 7, {7'd0, 7'd127, 7'd127, 7'd127}, 127, 127));
    // The node's id sits past the count, so it is not listed.
    add_pred(0, pkt(REQ_PKT, KIND_HEAD, 3, 9, 1, {7'd5, 7'd0, 7'd0, 7'd0}, 6, 0));
    add_pred(0, pkt(REQ_PKT, KIND_TOPO, 3, 9, 2, {7'd40, 7'd41, 7'd0, 7'd0}, 12, 0));
    add_pred(0, pkt(REQ_PKT, KIND_TOPO, 2, 200, 1, {7'd42, 7'd0, 7'd0, 7'd0}, 13, 0));
    // A topo packet with no heads still hands over head0.
    add_pred(0, pkt(REQ_PKT, KIND_TOPO, 3, 9, 0, {7'd55, 7'd1, 7'd1, 7'd1}, 14, 0));
    add_pred(0, pkt(REQ_PKT, KIND_JOIN, 77, 33, 3, {7'd9, 7'd9, 7'd9, 7'd9}, 90, 0));
    add_pred(0, pkt(REQ_PKT, KIND_HEAD, 32'hFFFF_FFFF, 1, 4, {7'd9, 7'd0, 7'd1, 7'd2}, 127, 0));
    add_pred(0, pkt(REQ_PKT, KIND_JOIN, 0, 255, 0, '0, 127, 0));
    add_pred(0, pkt(REQ_PKT, KIND_TOPO, 32'hFFFF_FFFF, 255, 4,
                    {7'd127, 7'd127, 7'd127, 7'd127}, 127, 127));
    add_pred(0, pkt(REQ_PKT, KIND_JOIN, 32'hFFFF_FFFF, 255, 7,
                    {7'd127, 7'd127, 7'd127, 7'd127}, 127, 0));
    hl = {7'd127, 7'd0, 7'd127, 7'd0};
    add_typed(1, pkt(REQ_START, KIND_JOIN, 32'hFFFF_FFFF, 255, 7, '1, 127, 127), 1,
              make_out(KIND_HEAD, 1, 255, 4, hl, 127, 0), '0);
    add_typed(1, pkt(REQ_START, KIND_HEAD, 0, 0, 0, '0, 0, 0), 1,
              make_out(KIND_HEAD, 1, 255, 4, hl, 127, 0), '0);
    add_typed(1, pkt(REQ_PKT, KIND_HEAD, 50, 5, 4, hl, 3, 0), 0, '0, '0);
    add_typed(1, pkt(REQ_PKT, KIND_JOIN, 0, 5, 0, '0, 3, 127), 0, '0, '0);
    add_typed(2, pkt(REQ_START, KIND_HEAD, 0, 0, 0, '0, 0, 0), 0, '0, '0);
    add_pred(2, pkt(REQ_PKT, KIND_HEAD, 1, 1, 4, {7'd1, 7'd2, 7'd3, 7'd127}, 64, 0));
    add_typed(3, pkt(REQ_START, KIND_HEAD, 0, 0, 0, '0, 0, 0), 0, '0, '0);
    add_pred(3, pkt(REQ_PKT, KIND_HEAD, 10, 2, 1, {7'd3, 7'd0, 7'd0, 7'd0}, 9, 0));
    // The stored level outranks this packet: only its sequence number is taken.
    add_pred(3, pkt(REQ_PKT, KIND_TOPO, 12, 50, 1, {7'd8, 7'd0, 7'd0, 7'd0}, 9, 0));
    // Already head for this round, so no second topo packet.
    add_pred(3, pkt(REQ_PKT, KIND_HEAD, 12, 2, 2, {7'd1, 7'd3, 7'd0, 7'd0}, 9, 0));
    add_pred(3, pkt(REQ_PKT, KIND_JOIN, 0, 4, 0, '0, 9, 3));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cur_ph = 0;
    foreach (plan[r]) begin
      if (plan[r].ph != cur_ph) begin
        settle();
        cur_ph = plan[r].ph;
        set_config(ph_node[cur_ph], ph_sink[cur_ph], ph_hop[cur_ph], ph_heads[cur_ph]);
      end
      send_packet(plan[r].it);
      n = node_step(plan[r].it);
      if (plan[r].typed) begin
        n           = plan[r].n;
        pred_res[0] = plan[r].e0;
        pred_res[1] = plan[r].e1;
      end
      for (int i = 0; i < n; i++) outgoing_q.push_back(pred_res[i]);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      hl = {7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
      set_config((p == 0) ? 7'd0 : (p == 1) ? 7'd127 : 7'($urandom_range(0, 127)),
                 (p == 2 || p == 5) ? 1'b1 : (p == 7) ? 1'($urandom_range(0, 1)) : 1'b0,
                 (p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'($urandom_range(0, 255)), hl);
      for (int k = 0; k < 100; k++) begin
        if (p == 4 && k == 50) settle();
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        it = random_packet();
        send_packet(it);
        n = node_step(it);
        for (int i = 0; i < n; i++) outgoing_q.push_back(pred_res[i]);
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && outgoing_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
